// File: src/ppt_pkg.sv
// Package for the projective point transform: payload types, register codes,
// reset values and datapath widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ppt_pkg;

	localparam int unsigned DEF_ORIGIN_WEIGHT = 26214400;
	localparam int unsigned DEF_FRAC_BITS     = 16;

	// Widths cover the full fraction range of 8 to 24 bits.
	localparam int unsigned DW   = 66;
	localparam int unsigned NW   = 98;
	localparam int unsigned RW   = 99;
	localparam int unsigned QW   = 33;
	localparam int unsigned NREG = 8;
	localparam int unsigned IW   = 3;

	localparam logic [IW-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [IW-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [IW-1:0] REG_GAIN_XX  = 3'd2;
	localparam logic [IW-1:0] REG_GAIN_YX  = 3'd3;
	localparam logic [IW-1:0] REG_GAIN_XY  = 3'd4;
	localparam logic [IW-1:0] REG_GAIN_YY  = 3'd5;
	localparam logic [IW-1:0] REG_WEIGHT_X = 3'd6;
	localparam logic [IW-1:0] REG_WEIGHT_Y = 3'd7;

	localparam logic signed [31:0] RST_ORIGIN = 32'sd0;
	localparam logic signed [31:0] RST_GAIN   = 32'sd39321600;
	localparam logic signed [31:0] RST_WEIGHT = 32'sd65536;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} in_t;

	typedef struct packed {
		logic signed [31:0] mapped_x;
		logic signed [31:0] mapped_y;
		logic               zero_denominator;
		logic               saturated;
	} out_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] gain_xx;
		logic signed [31:0] gain_yx;
		logic signed [31:0] gain_xy;
		logic signed [31:0] gain_yy;
		logic signed [31:0] weight_x;
		logic signed [31:0] weight_y;
	} cfg_t;

	typedef struct packed {
		logic [RW-1:0] rem_x;
		logic [RW-1:0] rem_y;
		logic [DW-1:0] den;
		logic [QW-1:0] quo_x;
		logic [QW-1:0] quo_y;
		logic          neg_x;
		logic          neg_y;
		logic          ovf_x;
		logic          ovf_y;
		logic          zero;
	} div_t;

endpackage
`default_nettype wire

// File: src/projective_point_transform.sv
// Top level of the projective point transform: registers, front end,
// divider cell chain and output register. Depends on ppt_pkg and submodules.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | in_data  (ppt_pkg::in_t)
//  out     | output    | out_valid/out_stall | out_data (ppt_pkg::out_t)
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One point is taken per cycle while in_stall is low; each result passes, after its transfer
// in, through six front stages, 33 divider cells (one quotient bit each) and the output.
// Every stage holds its item only while the next is full and stalled, so bubbles
// close up and input keeps flowing while a result waits. Reset clears valid bits
// and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module projective_point_transform #(
	parameter logic signed [31:0] ORIGIN_WEIGHT = ppt_pkg::DEF_ORIGIN_WEIGHT,
	parameter int unsigned        FRAC_BITS     = ppt_pkg::DEF_FRAC_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire ppt_pkg::in_t           in_data,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output ppt_pkg::out_t               out_data,
	input  wire logic                   cfg_we,
	input  wire logic [ppt_pkg::IW-1:0] cfg_index,
	input  wire logic [31:0]            cfg_data
);
	localparam int unsigned QW = ppt_pkg::QW;

	ppt_pkg::cfg_t cfg_q;
	logic front_ready;
	logic [QW:0] v;
	logic [QW:0] r;
	ppt_pkg::div_t d [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= ppt_pkg::RST_ORIGIN;
			cfg_q.origin_y <= ppt_pkg::RST_ORIGIN;
			cfg_q.gain_xx  <= ppt_pkg::RST_GAIN;
			cfg_q.gain_yx  <= ppt_pkg::RST_ORIGIN;
			cfg_q.gain_xy  <= ppt_pkg::RST_ORIGIN;
			cfg_q.gain_yy  <= ppt_pkg::RST_GAIN;
			cfg_q.weight_x <= ppt_pkg::RST_WEIGHT;
			cfg_q.weight_y <= ppt_pkg::RST_WEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppt_pkg::REG_ORIGIN_X: cfg_q.origin_x <= cfg_data;
				ppt_pkg::REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data;
				ppt_pkg::REG_GAIN_XX:  cfg_q.gain_xx  <= cfg_data;
				ppt_pkg::REG_GAIN_YX:  cfg_q.gain_yx  <= cfg_data;
				ppt_pkg::REG_GAIN_XY:  cfg_q.gain_xy  <= cfg_data;
				ppt_pkg::REG_GAIN_YY:  cfg_q.gain_yy  <= cfg_data;
				ppt_pkg::REG_WEIGHT_X: cfg_q.weight_x <= cfg_data;
				ppt_pkg::REG_WEIGHT_Y: cfg_q.weight_y <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = !front_ready;

	ppt_front #(
		.ORIGIN_WEIGHT(ORIGIN_WEIGHT),
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.valid_i(in_valid),
		.ready_o(front_ready),
		.data_i(in_data),
		.valid_o(v[0]),
		.ready_i(r[0]),
		.data_o(d[0])
	);

	for (genvar k = 0; k < QW; k++) begin : g_cell
		ppt_div_cell #(
			.BIT(QW - 1 - k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.valid_i(v[k]),
			.ready_o(r[k]),
			.data_i(d[k]),
			.valid_o(v[k+1]),
			.ready_i(r[k+1]),
			.data_o(d[k+1])
		);
	end

	ppt_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.valid_i(v[QW]),
		.ready_o(r[QW]),
		.data_i(d[QW]),
		.valid_o(out_valid),
		.stall_i(out_stall),
		.data_o(out_data)
	);
endmodule
`default_nettype wire

// File: src/ppt_front.sv
// Front end of the transform: products, sums, magnitudes and range check.
// Uses ppt_pkg types and widths; feeds the first divider cell.
`timescale 1ns / 1ps
`default_nettype none
module ppt_front #(
	parameter logic signed [31:0] ORIGIN_WEIGHT = ppt_pkg::DEF_ORIGIN_WEIGHT,
	parameter int unsigned        FRAC_BITS     = ppt_pkg::DEF_FRAC_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ppt_pkg::cfg_t cfg,
	input  wire logic          valid_i,
	output logic               ready_o,
	input  wire ppt_pkg::in_t  data_i,
	output logic               valid_o,
	input  wire logic          ready_i,
	output ppt_pkg::div_t      data_o
);
	localparam int unsigned DW = ppt_pkg::DW;
	localparam int unsigned NW = ppt_pkg::NW;
	localparam int unsigned RW = ppt_pkg::RW;
	localparam int unsigned QW = ppt_pkg::QW;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic r1, r2, r3, r4, r5, r6;

	logic signed [63:0] ax_s1, ay_s1;
	logic signed [DW-1:0] den_s2, den_s3, den_s4;
	logic signed [63:0] pxxh_s2, pyxh_s2, pxyh_s2, pyyh_s2, ox_s2, oy_s2;
	logic signed [64:0] pxxl_s2, pyxl_s2, pxyl_s2, pyyl_s2;
	logic signed [NW-1:0] txx_s3, tyx_s3, txy_s3, tyy_s3, cx_s3, cy_s3;
	logic signed [NW-1:0] nx_s4, ny_s4;
	logic [NW-1:0] mx_s5, my_s5;
	logic [DW-1:0] md_s5;
	logic nx_neg_s5, ny_neg_s5, zero_s5;
	ppt_pkg::div_t d_s6;
	logic [RW-1:0] lim;

	assign r6 = !v_s6 || ready_i;
	assign r5 = !v_s5 || r6;
	assign r4 = !v_s4 || r5;
	assign r3 = !v_s3 || r4;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;
	assign ready_o = r1;
	assign valid_o = v_s6;
	assign data_o  = d_s6;
	assign lim = RW'(md_s5) << QW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (r1) v_s1 <= valid_i;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
			if (r4) v_s4 <= v_s3;
			if (r5) v_s5 <= v_s4;
			if (r6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (r1 && valid_i) begin
			ax_s1 <= cfg.weight_x * data_i.point_x;
			ay_s1 <= cfg.weight_y * data_i.point_y;
		end
		if (r2 && v_s1) begin
			den_s2 <= (DW'(ORIGIN_WEIGHT) <<< FRAC_BITS) + DW'(ax_s1) + DW'(ay_s1);
			pxxh_s2 <= cfg.gain_xx * $signed(ax_s1[63:32]);
			pyxh_s2 <= cfg.gain_yx * $signed(ax_s1[63:32]);
			pxyh_s2 <= cfg.gain_xy * $signed(ay_s1[63:32]);
			pyyh_s2 <= cfg.gain_yy * $signed(ay_s1[63:32]);
			pxxl_s2 <= 65'(cfg.gain_xx) * $signed({1'b0, ax_s1[31:0]});
			pyxl_s2 <= 65'(cfg.gain_yx) * $signed({1'b0, ax_s1[31:0]});
			pxyl_s2 <= 65'(cfg.gain_xy) * $signed({1'b0, ay_s1[31:0]});
			pyyl_s2 <= 65'(cfg.gain_yy) * $signed({1'b0, ay_s1[31:0]});
			ox_s2 <= cfg.origin_x * ORIGIN_WEIGHT;
			oy_s2 <= cfg.origin_y * ORIGIN_WEIGHT;
		end
		if (r3 && v_s2) begin
			den_s3 <= den_s2;
			txx_s3 <= (NW'(pxxh_s2) <<< 32) + NW'(pxxl_s2);
			tyx_s3 <= (NW'(pyxh_s2) <<< 32) + NW'(pyxl_s2);
			txy_s3 <= (NW'(pxyh_s2) <<< 32) + NW'(pxyl_s2);
			tyy_s3 <= (NW'(pyyh_s2) <<< 32) + NW'(pyyl_s2);
			cx_s3 <= NW'(ox_s2) <<< FRAC_BITS;
			cy_s3 <= NW'(oy_s2) <<< FRAC_BITS;
		end
		if (r4 && v_s3) begin
			den_s4 <= den_s3;
			nx_s4 <= cx_s3 + txx_s3 + txy_s3;
			ny_s4 <= cy_s3 + tyx_s3 + tyy_s3;
		end
		if (r5 && v_s4) begin
			zero_s5   <= (den_s4 == '0);
			md_s5     <= den_s4[DW-1] ? DW'(-den_s4) : DW'(den_s4);
			mx_s5     <= nx_s4[NW-1] ? NW'(-nx_s4) : NW'(nx_s4);
			my_s5     <= ny_s4[NW-1] ? NW'(-ny_s4) : NW'(ny_s4);
			nx_neg_s5 <= nx_s4[NW-1] ^ den_s4[DW-1];
			ny_neg_s5 <= ny_s4[NW-1] ^ den_s4[DW-1];
		end
		if (r6 && v_s5) begin
			d_s6.rem_x <= RW'(mx_s5);
			d_s6.rem_y <= RW'(my_s5);
			d_s6.den   <= md_s5;
			d_s6.quo_x <= '0;
			d_s6.quo_y <= '0;
			d_s6.neg_x <= nx_neg_s5;
			d_s6.neg_y <= ny_neg_s5;
			d_s6.ovf_x <= RW'(mx_s5) >= lim;
			d_s6.ovf_y <= RW'(my_s5) >= lim;
			d_s6.zero  <= zero_s5;
		end
	end
endmodule
`default_nettype wire

// File: src/ppt_div_cell.sv
// One restoring-division cell: settles one quotient bit for x and for y.
// Uses ppt_pkg::div_t; cells are chained from the top bit down to bit zero.
`timescale 1ns / 1ps
`default_nettype none
module ppt_div_cell #(
	parameter int unsigned BIT = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid_i,
	output logic               ready_o,
	input  wire ppt_pkg::div_t data_i,
	output logic               valid_o,
	input  wire logic          ready_i,
	output ppt_pkg::div_t      data_o
);
	localparam int unsigned RW = ppt_pkg::RW;

	logic v_q;
	ppt_pkg::div_t d_q;
	ppt_pkg::div_t nxt;
	logic [RW-1:0] sub;
	logic ge_x, ge_y;

	assign sub  = RW'(data_i.den) << BIT;
	assign ge_x = data_i.rem_x >= sub;
	assign ge_y = data_i.rem_y >= sub;
	assign ready_o = !v_q || ready_i;
	assign valid_o = v_q;
	assign data_o  = d_q;

	always_comb begin
		nxt = data_i;
		if (ge_x) begin
			nxt.rem_x      = data_i.rem_x - sub;
			nxt.quo_x[BIT] = 1'b1;
		end
		if (ge_y) begin
			nxt.rem_y      = data_i.rem_y - sub;
			nxt.quo_y[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ready_o) begin
			v_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			d_q <= nxt;
		end
	end
endmodule
`default_nettype wire

// File: src/ppt_out.sv
// Output register: applies sign, saturation and the zero-denominator rule.
// Uses ppt_pkg types; takes the last divider cell's transfer.
`timescale 1ns / 1ps
`default_nettype none
module ppt_out (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid_i,
	output logic               ready_o,
	input  wire ppt_pkg::div_t data_i,
	output logic               valid_o,
	input  wire logic          stall_i,
	output ppt_pkg::out_t      data_o
);
	localparam int unsigned QW = ppt_pkg::QW;
	localparam logic [QW-1:0] POS_MAX = QW'(32'h7FFF_FFFF);
	localparam logic [QW-1:0] NEG_MAX = QW'(32'h8000_0000);

	logic v_q;
	ppt_pkg::out_t o_q;
	logic sat_x, sat_y;
	logic [31:0] res_x, res_y;

	assign sat_x = data_i.ovf_x || (data_i.neg_x ? data_i.quo_x > NEG_MAX
						     : data_i.quo_x > POS_MAX);
	assign sat_y = data_i.ovf_y || (data_i.neg_y ? data_i.quo_y > NEG_MAX
						     : data_i.quo_y > POS_MAX);

	always_comb begin
		if (data_i.zero) res_x = '0;
		else if (sat_x) res_x = data_i.neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else res_x = data_i.neg_x ? -data_i.quo_x[31:0] : data_i.quo_x[31:0];
		if (data_i.zero) res_y = '0;
		else if (sat_y) res_y = data_i.neg_y ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else res_y = data_i.neg_y ? -data_i.quo_y[31:0] : data_i.quo_y[31:0];
	end

	assign ready_o = !v_q || !stall_i;
	assign valid_o = v_q;
	assign data_o  = o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ready_o) begin
			v_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			o_q.mapped_x         <= res_x;
			o_q.mapped_y         <= res_y;
			o_q.zero_denominator <= data_i.zero;
			o_q.saturated        <= !data_i.zero && (sat_x || sat_y);
		end
	end
endmodule
`default_nettype wire

// File: src/ppt_checker.sv
// Port-level checks for the projective point transform, bound to the top level.
// Depends on ppt_pkg and projective_point_transform.
`timescale 1ns / 1ps
`default_nettype none
module ppt_checker (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_stall,
	input wire ppt_pkg::in_t           in_data,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire ppt_pkg::out_t          out_data,
	input wire logic                   cfg_we,
	input wire logic [ppt_pkg::IW-1:0] cfg_index,
	input wire logic [31:0]            cfg_data
);
	// An empty output register means every stage can move.
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while the output is empty");

	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zero_denominator |->
		out_data.mapped_x == 32'sd0 && out_data.mapped_y == 32'sd0 &&
		!out_data.saturated)
		else $error("zero denominator result is not cleared");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("stalled input transfer changed");

	a_cfg_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !$isunknown(cfg_index) && !$isunknown(cfg_data))
		else $error("register write with unknown index or data");
endmodule

bind projective_point_transform ppt_checker u_ppt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.in_data(in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data),
	.cfg_we(cfg_we),
	.cfg_index(cfg_index),
	.cfg_data(cfg_data)
);
`default_nettype wire
